// File: design/gdn_pkg.sv
// Shared types and constants for the Gregorian day number converter.
// Used by gdn_ctrl, gdn_dp and the top level; depends on nothing.
package gdn_pkg;

  localparam int unsigned DN_W   = 22;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned DBY_W  = 24;
  localparam int unsigned DOY_W  = 9;

  localparam logic [21:0] RECIP_366       = 22'd2933721;
  localparam int unsigned RECIP_366_SHIFT = 30;
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int unsigned RECIP_100_SHIFT = 19;

  localparam logic signed [DBY_W-1:0] DBY_YEAR_ZERO = -24'sd366;

  localparam logic OP_TO_NUMBER = 1'b0;
  localparam logic OP_TO_DATE   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EST,
    S_E1,
    S_E2,
    S_DOY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic est;
    logic e1;
    logic take;
    logic doy;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic gt;
    logic out_free;
  } status_t;

  // Days of a year before the first of month m.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m, input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      4'd13:   base = 9'd365;
      4'd14:   base = 9'd396;
      4'd15:   base = 9'd427;
      default: base = 9'd0;
    endcase
    return base + {8'd0, (leap && (m >= 4'd3))};
  endfunction

endpackage

// File: design/gregorian_day_number_convert_unit.sv
// Top level of the Gregorian day number converter.
// Depends on gdn_pkg, gdn_ctrl and gdn_dp.
//
//  channel | handshake           | payload
//  in      | in_valid, in_stall   | op, day, month, year, day_number
//  out     | out_valid, out_stall | out_day, out_month, out_year, out_day_number
//
// Date to number runs the estimate, the year evaluation and the output in that order.
// Number to date steps the year up k times after the n/366 estimate
// (k <= 25 over the full 22-bit range), then finds the day of year and the output.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset: synchronous, clears the sequencer and out_valid.
module gregorian_day_number_convert_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       op,
  input  logic [gdn_pkg::DAY_W-1:0]  day,
  input  logic [gdn_pkg::MON_W-1:0]  month,
  input  logic [gdn_pkg::YEAR_W-1:0] year,
  input  logic [gdn_pkg::DN_W-1:0]   day_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gdn_pkg::DAY_W-1:0]  out_day,
  output logic [gdn_pkg::MON_W-1:0]  out_month,
  output logic [gdn_pkg::YEAR_W-1:0] out_year,
  output logic [gdn_pkg::DN_W-1:0]   out_day_number
);
  import gdn_pkg::*;

  cmd_t    cmd;
  status_t status;

  gdn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gdn_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .op             (op),
    .day            (day),
    .month          (month),
    .year           (year),
    .day_number     (day_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_day_number (out_day_number)
  );

endmodule

// File: design/gdn_ctrl.sv
// Sequencer for the day number converter: estimate, year stepping, month and output.
// Depends on gdn_pkg; drives gdn_dp through cmd_t and reads status_t.
module gdn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  gdn_pkg::status_t status,
  output gdn_pkg::cmd_t    cmd
);
  import gdn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EST;
      end
      S_EST: state_next = S_E1;
      S_E1:  state_next = S_E2;
      S_E2: begin
        if (status.op == OP_TO_NUMBER) state_next = S_FIN;
        else if (status.gt)            state_next = S_E1;
        else                           state_next = S_DOY;
      end
      S_DOY: state_next = S_FIN;
      S_FIN: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:  cmd.load = in_valid;
      S_EST:   cmd.est  = 1'b1;
      S_E1:    cmd.e1   = 1'b1;
      S_E2:    cmd.take = (status.op == OP_TO_NUMBER) || status.gt;
      S_DOY:   cmd.doy  = 1'b1;
      S_FIN:   cmd.fin  = status.out_free;
      default: cmd      = '0;
    endcase
  end

endmodule

// File: design/gdn_dp.sv
// Datapath of the day number converter: item registers, year evaluation,
// month lookup and the output register. Depends on gdn_pkg.
module gdn_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  gdn_pkg::cmd_t              cmd,
  output gdn_pkg::status_t           status,
  input  logic                       op,
  input  logic [gdn_pkg::DAY_W-1:0]  day,
  input  logic [gdn_pkg::MON_W-1:0]  month,
  input  logic [gdn_pkg::YEAR_W-1:0] year,
  input  logic [gdn_pkg::DN_W-1:0]   day_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gdn_pkg::DAY_W-1:0]  out_day,
  output logic [gdn_pkg::MON_W-1:0]  out_month,
  output logic [gdn_pkg::YEAR_W-1:0] out_year,
  output logic [gdn_pkg::DN_W-1:0]   out_day_number
);
  import gdn_pkg::*;

  logic                     op_r;
  logic [DAY_W-1:0]         day_r;
  logic [MON_W-1:0]         month_r;
  logic [YEAR_W-1:0]        year_r;
  logic [DN_W-1:0]          dn_r;
  logic [YEAR_W-1:0]        ye;
  logic [YEAR_W-1:0]        yr;
  logic                     zero_r;
  logic [YEAR_W-1:0]        p_r;
  logic [22:0]              m365;
  logic [7:0]               q100;
  logic signed [DBY_W-1:0]  dby_lo;
  logic                     leap_lo;
  logic [DOY_W-1:0]         doy;

  logic [43:0]              est_prod;
  logic [YEAR_W-1:0]        p_next;
  logic [26:0]              q100_prod;
  logic [5:0]               q400;
  logic [DBY_W-1:0]         dby_sum;
  logic signed [DBY_W-1:0]  dby_next;
  logic [YEAR_W-1:0]        r100;
  logic [YEAR_W-1:0]        r400;
  logic                     leap_next;
  logic [DBY_W-1:0]         doy_diff;
  logic [MON_W-1:0]         mo_cnt;
  logic [MON_W-1:0]         mo;
  logic [DOY_W-1:0]         dy_full;
  logic [DBY_W-1:0]         dn_sum;

  assign est_prod  = {22'd0, dn_r} * {22'd0, RECIP_366};
  assign p_next    = ye - 14'd1;
  assign q100_prod = {13'd0, p_next} * {14'd0, RECIP_100};

  assign q400      = q100[7:2];
  assign dby_sum   = {1'b0, m365} + {12'd0, p_r[13:2]} - {16'd0, q100} + {18'd0, q400};
  assign dby_next  = zero_r ? DBY_YEAR_ZERO : $signed(dby_sum);
  assign r100      = p_r - ({6'd0, q100} * 14'd100);
  assign r400      = p_r - ({8'd0, q400} * 14'd400);
  assign leap_next = zero_r || ((p_r[1:0] == 2'b11) && (r100 != 14'd99)) || (r400 == 14'd399);

  assign doy_diff  = {2'b00, dn_r} - dby_lo;

  always_comb begin
    mo_cnt = '0;
    for (int k = 1; k <= 11; k++) begin
      if (doy > cum_days(MON_W'(k + 1), leap_lo)) mo_cnt = mo_cnt + 4'd1;
    end
    mo      = mo_cnt + 4'd1;
    dy_full = doy - cum_days(mo, leap_lo);
  end

  assign dn_sum = {19'd0, day_r} + {15'd0, cum_days(month_r, leap_lo)} + dby_lo;

  assign status.op       = op_r;
  assign status.gt       = $signed({2'b00, dn_r}) > dby_next;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      day_r   <= day;
      month_r <= month;
      year_r  <= year;
      dn_r    <= day_number;
    end
    if (cmd.est) begin
      ye <= (op_r == OP_TO_DATE) ? est_prod[RECIP_366_SHIFT +: YEAR_W] : year_r;
    end
    if (cmd.e1) begin
      zero_r <= (ye == '0);
      p_r    <= p_next;
      m365   <= {9'd0, p_next} * 23'd365;
      q100   <= q100_prod[RECIP_100_SHIFT +: 8];
    end
    if (cmd.take) begin
      yr      <= ye;
      dby_lo  <= dby_next;
      leap_lo <= leap_next;
      ye      <= ye + 14'd1;
    end
    if (cmd.doy) begin
      doy <= doy_diff[DOY_W-1:0];
    end
    if (cmd.fin) begin
      if (op_r == OP_TO_NUMBER) begin
        out_day        <= day_r;
        out_month      <= month_r;
        out_year       <= year_r;
        out_day_number <= dn_sum[DN_W-1:0];
      end else begin
        out_day        <= dy_full[DAY_W-1:0];
        out_month      <= mo;
        out_year       <= yr;
        out_day_number <= dn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/gdn_checker.sv
// Port-level checks for the Gregorian day number converter, bound to the top level.
// Depends on gdn_pkg for field widths.
module gdn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [gdn_pkg::DN_W-1:0]   out_day_number
);
  import gdn_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after an item");

  a_result_ends_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(in_stall) && !in_stall))
    else $error("result not tied to an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_day_number)))
    else $error("stalled item changed");

endmodule

bind gregorian_day_number_convert_unit gdn_checker u_gdn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_day_number (out_day_number)
);

// File: bench/gdn_result_checker.sv
// Result checker for the Gregorian day number converter: predicts each item, compares results.
// Depends on gdn_pkg; instantiated by gregorian_day_number_convert_unit_tb.
`timescale 1ns / 1ps

module gdn_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       op,
  input  logic [gdn_pkg::DAY_W-1:0]  day,
  input  logic [gdn_pkg::MON_W-1:0]  month,
  input  logic [gdn_pkg::YEAR_W-1:0] year,
  input  logic [gdn_pkg::DN_W-1:0]   day_number,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [gdn_pkg::DAY_W-1:0]  out_day,
  input  logic [gdn_pkg::MON_W-1:0]  out_month,
  input  logic [gdn_pkg::YEAR_W-1:0] out_year,
  input  logic [gdn_pkg::DN_W-1:0]   out_day_number,
  output int                         mismatches,
  output int                         outstanding
);
  import gdn_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [DN_W-1:0]   day_number;
  } calendar_t;

  calendar_t due_results[$];

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(input longint m, input longint y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic longint serial_of(input longint d, input longint m, input longint y);
    longint acc;
    longint k;
    longint p;
    acc = d;
    for (k = m - 1; k > 0; k--) acc += month_days(k, y);
    if (y <= 0) return acc - 366;
    p = y - 1;
    return acc + 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic calendar_t predict_conversion(
    input logic              o,
    input logic [DAY_W-1:0]  d,
    input logic [MON_W-1:0]  m,
    input logic [YEAR_W-1:0] y,
    input logic [DN_W-1:0]   n_in
  );
    calendar_t r;
    longint n;
    longint yr;
    longint mo;
    longint v;
    r.day        = d;
    r.month      = m;
    r.year       = y;
    r.day_number = n_in;
    if (o == OP_TO_NUMBER) begin
      v = serial_of(d, m, y);
      r.day_number = v[DN_W-1:0];
    end else begin
      n  = n_in;
      yr = n / 366;
      while (n >= serial_of(1, 1, yr + 1)) yr++;
      mo = 1;
      while (mo < 12 && n > serial_of(month_days(mo, yr), mo, yr)) mo++;
      v = n - serial_of(1, mo, yr) + 1;
      r.day   = v[DAY_W-1:0];
      r.month = mo[MON_W-1:0];
      r.year  = yr[YEAR_W-1:0];
    end
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    calendar_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no item outstanding: day %0d month %0d year %0d number %0d",
                   $time, out_day, out_month, out_year, out_day_number);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_day !== want.day) begin
            $display("%0t: out_day expected %0d, got %0d", $time, want.day, out_day);
            mismatches++;
          end
          if (out_month !== want.month) begin
            $display("%0t: out_month expected %0d, got %0d", $time, want.month, out_month);
            mismatches++;
          end
          if (out_year !== want.year) begin
            $display("%0t: out_year expected %0d, got %0d", $time, want.year, out_year);
            mismatches++;
          end
          if (out_day_number !== want.day_number) begin
            $display("%0t: out_day_number expected %0d, got %0d",
                     $time, want.day_number, out_day_number);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(predict_conversion(op, day, month, year, day_number));
      outstanding = due_results.size();
    end
  end

endmodule

// File: bench/gregorian_day_number_convert_unit_tb.sv
// Top of the converter regression: clock, reset, stimulus, idling and the verdict.
// Depends on gdn_pkg, gdn_result_checker and gregorian_day_number_convert_unit.
`timescale 1ns / 1ps

module gregorian_day_number_convert_unit_tb;
  import gdn_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [DAY_W-1:0]  day;
  logic [MON_W-1:0]  month;
  logic [YEAR_W-1:0] year;
  logic [DN_W-1:0]   day_number;
  logic              out_valid;
  logic              out_stall;
  logic [DAY_W-1:0]  out_day;
  logic [MON_W-1:0]  out_month;
  logic [YEAR_W-1:0] out_year;
  logic [DN_W-1:0]   out_day_number;
  int                mismatches;
  int                outstanding;
  bit                idle_on;
  bit                long_hold;

  gregorian_day_number_convert_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .day(day), .month(month), .year(year), .day_number(day_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_day(out_day), .out_month(out_month), .out_year(out_year),
    .out_day_number(out_day_number)
  );

  gdn_result_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .day(day), .month(month), .year(year), .day_number(day_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_day(out_day), .out_month(out_month), .out_year(out_year),
    .out_day_number(out_day_number),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("gregorian_day_number_convert_unit regression: fail");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (100) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int jan1_serial(input int y);
    return 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
  endfunction

  task automatic send_item(
    input logic              o,
    input logic [DAY_W-1:0]  d,
    input logic [MON_W-1:0]  m,
    input logic [YEAR_W-1:0] y,
    input logic [DN_W-1:0]   n
  );
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    op         <= o;
    day        <= d;
    month      <= m;
    year       <= y;
    day_number <= n;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic              o;
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    logic [DN_W-1:0]   n;
    int                sel;
    int                top_day;
    sel = $urandom_range(0, 9);
    o   = 1'($urandom_range(0, 1));
    d   = DAY_W'($urandom);
    m   = MON_W'($urandom);
    y   = YEAR_W'($urandom);
    n   = DN_W'($urandom);
    if (sel != 0) begin
      if (o == OP_TO_NUMBER) begin
        case ($urandom_range(0, 3))
          0: y = YEAR_W'($urandom_range(1, 99) * 100);
          1: y = YEAR_W'($urandom_range(1, 2499) * 4);
          default: y = YEAR_W'($urandom_range(1, 9999));
        endcase
        m = MON_W'($urandom_range(1, 12));
        if (m == 2)
          top_day = (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
        else if (m == 4 || m == 6 || m == 9 || m == 11)
          top_day = 30;
        else
          top_day = 31;
        d = DAY_W'($urandom_range(1, top_day));
      end else if (sel < 4) begin
        n = DN_W'(jan1_serial($urandom_range(1, 9999)) + $urandom_range(0, 61) - 1);
      end else begin
        n = DN_W'($urandom_range(1, 3652059));
      end
    end
    send_item(o, d, m, y, n);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_TO_NUMBER;
    day        = '0;
    month      = '0;
    year       = '0;
    day_number = '0;
    idle_on    = 1'b1;
    long_hold  = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_item(OP_TO_NUMBER, 5'd1, 4'd1, 14'd1, 22'd0);
    send_item(OP_TO_NUMBER, 5'd31, 4'd12, 14'd9999, '1);
    send_item(OP_TO_NUMBER, 5'd29, 4'd2, 14'd2000, 22'd0);
    send_item(OP_TO_NUMBER, 5'd1, 4'd3, 14'd1900, 22'd0);
    send_item(OP_TO_NUMBER, 5'd29, 4'd2, 14'd2024, 22'd0);
    send_item(OP_TO_NUMBER, 5'd31, 4'd12, 14'd0, 22'd0);
    send_item(OP_TO_NUMBER, 5'd0, 4'd0, 14'd0, 22'd0);
    send_item(OP_TO_NUMBER, 5'd31, 4'd15, 14'd16383, '1);
    send_item(OP_TO_NUMBER, 5'd0, 4'd1, 14'd1, 22'd0);
    send_item(OP_TO_NUMBER, 5'd20, 4'd13, 14'd4, 22'd0);
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'd0);
    send_item(OP_TO_DATE, 5'd31, 4'd15, 14'd16383, 22'd1);
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'd3652059);
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, '1);
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, DN_W'(jan1_serial(2000) + 59));
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, DN_W'(jan1_serial(1901) - 1));
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, DN_W'(jan1_serial(2001) - 1));
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, DN_W'(jan1_serial(2001)));
    send_item(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'd60);

    for (int i = 0; i < 1430; i++) begin
      if (i == 600) long_hold = 1'b1;
      if (i == 900) drain();
      if (i == 1150) idle_on = 1'b0;
      send_random();
    end

    drain();
    repeat (64) @(negedge clk);
    if (mismatches == 0)
      $display("gregorian_day_number_convert_unit regression: pass");
    else
      $display("gregorian_day_number_convert_unit regression: fail");
    $finish;
  end

endmodule
